/* design/pip_pkg.sv */
package pip_pkg;

  typedef enum logic [1:0] {
    ORI_COLLINEAR,
    ORI_CW,
    ORI_CCW
  } orient_t;

  typedef struct packed {
    logic first;
    logic last;
  } job_flags_t;

  typedef struct packed {
    logic hit;
    logic collinear;
    logic on_edge;
  } edge_res_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] TALLY_ONE  = 2'd1;
  localparam logic [1:0] TALLY_FULL = 2'd3;

  function automatic orient_t sign_to_orient(input logic is_zero, input logic is_neg);
    orient_t o;
    if (is_zero) begin
      o = ORI_COLLINEAR;
    end else if (is_neg) begin
      o = ORI_CCW;
    end else begin
      o = ORI_CW;
    end
    return o;
  endfunction

endpackage

/* design/pip_in_if.sv */
interface pip_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic                first;
  logic                last;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y, first, last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y, first, last,
    output ready
  );
endinterface

/* design/pip_out_if.sv */
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic decided_by_collinear;
  logic too_few_vertices;

  modport source (
    output valid, inside_res, decided_by_collinear, too_few_vertices,
    input  ready
  );

  modport sink (
    input  valid, inside_res, decided_by_collinear, too_few_vertices,
    output ready
  );
endinterface

/* design/pip_front.sv */
module pip_front #(
  parameter int W = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  pip_in_if.sink                                          vertices,
  output logic                                            push_valid,
  input  logic                                            push_ready,
  output logic [8*W+$bits(pip_pkg::job_flags_t)-1:0]      push_data
);
  logic signed [W-1:0] query_x;
  logic signed [W-1:0] query_y;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] prev_x;
  logic signed [W-1:0] prev_y;

  logic signed [W-1:0] job_px;
  logic signed [W-1:0] job_py;
  logic signed [W-1:0] job_sx;
  logic signed [W-1:0] job_sy;
  pip_pkg::job_flags_t flags;
  logic                accept;

  assign vertices.ready = push_ready;
  assign push_valid     = vertices.valid;
  assign accept         = vertices.valid && push_ready;

  always_comb begin
    flags.first = vertices.first;
    flags.last  = vertices.last;
    job_px = vertices.first ? vertices.point_x  : query_x;
    job_py = vertices.first ? vertices.point_y  : query_y;
    job_sx = vertices.first ? vertices.vertex_x : start_x;
    job_sy = vertices.first ? vertices.vertex_y : start_y;
  end

  assign push_data = {flags, job_px, job_py, prev_x, prev_y,
                      vertices.vertex_x, vertices.vertex_y, job_sx, job_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      start_x <= '0;
      start_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else if (accept) begin
      query_x <= job_px;
      query_y <= job_py;
      start_x <= job_sx;
      start_y <= job_sy;
      prev_x  <= vertices.vertex_x;
      prev_y  <= vertices.vertex_y;
    end
  end
endmodule

/* design/pip_queue.sv */
module pip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule

/* design/pip_edge.sv */
module pip_edge #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [W-1:0] a_x,
  input  logic signed [W-1:0] a_y,
  input  logic signed [W-1:0] b_x,
  input  logic signed [W-1:0] b_y,
  input  logic signed [W-1:0] p_x,
  input  logic signed [W-1:0] p_y,
  input  logic signed [W-1:0] e_x,
  output pip_pkg::edge_res_t  res
);
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 1;

  logic signed [W-1:0] box_xlo, box_xhi, box_ylo, box_yhi, ray_xlo, ray_xhi;

  logic signed [DW-1:0] d_bya, d_pxb, d_bxa, d_pyb, d_exb, d_pya, d_bxp, d_pxa, d_exp;
  logic                 s1_on_p, s1_on_e, s1_on_a, s1_on_b;

  logic signed [PW-1:0] m1, m2, m3, m5a, m5b;
  pip_pkg::orient_t     o3, o4;
  logic                 s2_on_p, s2_on_e, s2_on_a, s2_on_b;

  logic signed [VW-1:0] v1, v2, v5;
  pip_pkg::orient_t     o1, o2;

  always_comb begin
    box_xlo = (a_x < b_x) ? a_x : b_x;
    box_xhi = (a_x < b_x) ? b_x : a_x;
    box_ylo = (a_y < b_y) ? a_y : b_y;
    box_yhi = (a_y < b_y) ? b_y : a_y;
    ray_xlo = (p_x < e_x) ? p_x : e_x;
    ray_xhi = (p_x < e_x) ? e_x : p_x;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_bya <= DW'(b_y) - DW'(a_y);
      d_pxb <= DW'(p_x) - DW'(b_x);
      d_bxa <= DW'(b_x) - DW'(a_x);
      d_pyb <= DW'(p_y) - DW'(b_y);
      d_exb <= DW'(e_x) - DW'(b_x);
      d_pya <= DW'(p_y) - DW'(a_y);
      d_bxp <= DW'(b_x) - DW'(p_x);
      d_pxa <= DW'(p_x) - DW'(a_x);
      d_exp <= DW'(e_x) - DW'(p_x);
      s1_on_p <= p_x >= box_xlo && p_x <= box_xhi && p_y >= box_ylo && p_y <= box_yhi;
      s1_on_e <= e_x >= box_xlo && e_x <= box_xhi && p_y >= box_ylo && p_y <= box_yhi;
      s1_on_a <= a_y == p_y && a_x >= ray_xlo && a_x <= ray_xhi;
      s1_on_b <= b_y == p_y && b_x >= ray_xlo && b_x <= ray_xhi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= PW'(d_bya) * PW'(d_pxb);
      m2  <= PW'(d_bxa) * PW'(d_pyb);
      m3  <= PW'(d_bya) * PW'(d_exb);
      m5a <= PW'(d_pya) * PW'(d_bxp);
      m5b <= PW'(d_pxa) * PW'(d_pyb);
      o3  <= pip_pkg::sign_to_orient(d_exp == '0 || d_pya == '0,
                                     d_exp[DW-1] ^ d_pya[DW-1]);
      o4  <= pip_pkg::sign_to_orient(d_exp == '0 || d_pyb == '0,
                                     d_exp[DW-1] ^ d_pyb[DW-1]);
      s2_on_p <= s1_on_p;
      s2_on_e <= s1_on_e;
      s2_on_a <= s1_on_a;
      s2_on_b <= s1_on_b;
    end
  end

  always_comb begin
    v1 = VW'(m1) - VW'(m2);
    v2 = VW'(m3) - VW'(m2);
    v5 = VW'(m5a) + VW'(m5b);
    o1 = pip_pkg::sign_to_orient(v1 == '0, v1[VW-1]);
    o2 = pip_pkg::sign_to_orient(v2 == '0, v2[VW-1]);
    res.hit = (o1 != o2 && o3 != o4)
           || (o1 == pip_pkg::ORI_COLLINEAR && s2_on_p)
           || (o2 == pip_pkg::ORI_COLLINEAR && s2_on_e)
           || (o3 == pip_pkg::ORI_COLLINEAR && s2_on_a)
           || (o4 == pip_pkg::ORI_COLLINEAR && s2_on_b);
    res.collinear = v5 == '0;
    res.on_edge   = s2_on_p;
  end
endmodule

/* design/pip_back.sv */
module pip_back #(
  parameter int W = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic signed [W-1:0]                        ray_end_x,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  logic [8*W+$bits(pip_pkg::job_flags_t)-1:0] pop_data,
  pip_out_if.source                                  results
);
  logic signed [W-1:0] j_px, j_py, j_ax, j_ay, j_bx, j_by, j_sx, j_sy;
  pip_pkg::job_flags_t j_flags;

  logic                adv;
  logic                s1_valid, s2_valid;
  pip_pkg::job_flags_t s1_flags, s2_flags;
  pip_pkg::edge_res_t  r1, r2;

  logic       crossing_parity, answer_latched, latched_answer;
  logic [1:0] vertex_tally;

  logic       lat0, ans0, par0, e1_on, lat1, ans1, par1, e2_on;
  logic       crossing_parity_next, answer_latched_next, latched_answer_next;
  logic [1:0] vertex_tally_next;
  logic       too_few;

  logic out_valid, out_inside, out_collinear, out_too_few;

  assign {j_flags, j_px, j_py, j_ax, j_ay, j_bx, j_by, j_sx, j_sy} = pop_data;

  assign adv       = !out_valid || results.ready;
  assign pop_ready = adv;

  pip_edge #(.W(W)) u_edge_open (
    .clk (clk),
    .adv (adv),
    .a_x (j_ax),
    .a_y (j_ay),
    .b_x (j_bx),
    .b_y (j_by),
    .p_x (j_px),
    .p_y (j_py),
    .e_x (ray_end_x),
    .res (r1)
  );

  pip_edge #(.W(W)) u_edge_close (
    .clk (clk),
    .adv (adv),
    .a_x (j_bx),
    .a_y (j_by),
    .b_x (j_sx),
    .b_y (j_sy),
    .p_x (j_px),
    .p_y (j_py),
    .e_x (ray_end_x),
    .res (r2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= j_flags;
      s2_flags <= s1_flags;
    end
  end

  always_comb begin
    lat0  = s2_flags.first ? 1'b0 : answer_latched;
    ans0  = s2_flags.first ? 1'b0 : latched_answer;
    par0  = s2_flags.first ? 1'b0 : crossing_parity;

    e1_on = !s2_flags.first && !lat0 && r1.hit;
    lat1  = lat0 || (e1_on && r1.collinear);
    ans1  = (e1_on && r1.collinear) ? r1.on_edge : ans0;
    par1  = par0 ^ (e1_on && !r1.collinear);

    e2_on = s2_flags.last && !lat1 && r2.hit;
    answer_latched_next  = lat1 || (e2_on && r2.collinear);
    latched_answer_next  = (e2_on && r2.collinear) ? r2.on_edge : ans1;
    crossing_parity_next = par1 ^ (e2_on && !r2.collinear);

    if (s2_flags.first) begin
      vertex_tally_next = pip_pkg::TALLY_ONE;
    end else if (vertex_tally == pip_pkg::TALLY_FULL) begin
      vertex_tally_next = vertex_tally;
    end else begin
      vertex_tally_next = vertex_tally + 2'd1;
    end
    too_few = vertex_tally_next != pip_pkg::TALLY_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
      crossing_parity <= 1'b0;
      answer_latched  <= 1'b0;
      latched_answer  <= 1'b0;
      vertex_tally    <= '0;
    end else if (adv) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_flags.last;
      if (s2_valid) begin
        crossing_parity <= crossing_parity_next;
        answer_latched  <= answer_latched_next;
        latched_answer  <= latched_answer_next;
        vertex_tally    <= vertex_tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_flags.last) begin
      out_too_few   <= too_few;
      out_collinear <= !too_few && answer_latched_next;
      out_inside    <= !too_few && (answer_latched_next ? latched_answer_next
                                                        : crossing_parity_next);
    end
  end

  assign results.valid                = out_valid;
  assign results.inside_res           = out_inside;
  assign results.decided_by_collinear = out_collinear;
  assign results.too_few_vertices     = out_too_few;
endmodule

/* design/point_in_polygon_test_unit.sv */
// Point-in-polygon test by horizontal ray casting on signed COORD_WIDTH-bit
// coordinates. Stream the polygon one vertex per word: the word marked first
// carries the query point and starts a new polygon, the word marked last closes
// the polygon back to its first vertex and yields exactly one result word; other
// words yield nothing. cfg_wr_data sets the x of the far ray end (reset: the
// largest positive coordinate); write it only while the unit is idle, which the
// unit does not enforce. The unit takes one vertex word per clock while results
// are taken; the queue, the difference stage, the registered multiplier stage
// and the output register lie between a last vertex and its result. A four-word
// queue sits between the vertex side and the evaluation pipeline.
module point_in_polygon_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic signed [COORD_WIDTH-1:0] cfg_wr_data,
  pip_in_if.sink                        vertices,
  pip_out_if.source                     results
);
  localparam int JOB_W = 8 * COORD_WIDTH + $bits(pip_pkg::job_flags_t);

  logic signed [COORD_WIDTH-1:0] ray_end_x;

  logic             q_push_valid;
  logic             q_push_ready;
  logic [JOB_W-1:0] q_push_data;
  logic             q_pop_valid;
  logic             q_pop_ready;
  logic [JOB_W-1:0] q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_end_x <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (cfg_wr_en) begin
      ray_end_x <= cfg_wr_data;
    end
  end

  pip_front #(.W(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .vertices   (vertices),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  pip_queue #(.WIDTH(JOB_W), .DEPTH(pip_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  pip_back #(.W(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .ray_end_x (ray_end_x),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .results   (results)
  );

  a_few_clears_answer: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.too_few_vertices
      |-> !results.inside_res && !results.decided_by_collinear)
    else $error("short polygon reported an answer");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    vertices.valid && vertices.ready |=> q_pop_valid)
    else $error("accepted vertex word missing from queue");

  a_stall_holds_queue: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !q_pop_ready)
    else $error("queue drained while result stalled");
endmodule
